>>> design/gwb_pkg.sv
// Shared types, constants and helper functions for the grey-world white balance block.
`timescale 1ns / 1ps
`default_nettype none
package gwb_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int PHASE_TOTAL = 4;

    localparam int FW_W     = 13;
    localparam int POS_W    = 12;
    localparam int SCOUNT_W = 25;
    localparam int SUM_W    = 32;
    localparam int CNT_W    = 23;
    localparam int MEAN_W   = 18;
    localparam int GAIN_W   = 16;
    localparam int SAMPLE_W = 10;
    localparam int PIXEL_W  = 15;
    localparam int CFG_W    = 18;
    localparam int IDX_W    = 3;

    // Iterative divider geometry: the widest dividend is a phase sum shifted by 8.
    localparam int DIV_N_W   = SUM_W + 8;
    localparam int DIV_D_W   = CNT_W;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(4096);
    localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};
    localparam logic [SCOUNT_W-1:0] SCOUNT_MAX = {SCOUNT_W{1'b1}};

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_APPLY   = 1'b1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_GAIN  = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [1:0] STATUS_DARK     = 2'd2;

    localparam logic [1:0] PH_RED  = 2'd0;
    localparam logic [1:0] PH_GR   = 2'd1;
    localparam logic [1:0] PH_GB   = 2'd2;
    localparam logic [1:0] PH_BLUE = 2'd3;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_BAYER_ORDER  = 3'd2;
    localparam logic [IDX_W-1:0] REG_MIN_MEAN     = 3'd3;
    localparam logic [IDX_W-1:0] REG_MIN_GAIN     = 3'd4;
    localparam logic [IDX_W-1:0] REG_MAX_GAIN     = 3'd5;

    typedef struct packed {
        logic [FW_W-1:0]   frame_width;
        logic [FW_W-1:0]   frame_height;
        logic [1:0]        bayer_order;
        logic [MEAN_W-1:0] mean_floor;
        logic [GAIN_W-1:0] gain_floor;
        logic [GAIN_W-1:0] gain_ceil;
    } cfg_t;

    // One classified sample handed from the front to the back.
    typedef struct packed {
        logic                opcode;
        logic [SAMPLE_W-1:0] sample;
        logic                last;
        logic [1:0]          phase;
        logic                mismatch;
    } cmd_t;

    function automatic logic [1:0] phase_map(input logic [1:0] order, input logic [1:0] pos);
        logic [1:0] ph;
        ph = PH_RED;
        unique case (order)
            2'd0: ph = (pos == 2'd0) ? PH_RED  : (pos == 2'd1) ? PH_GR   :
                       (pos == 2'd2) ? PH_GB   : PH_BLUE;
            2'd1: ph = (pos == 2'd0) ? PH_BLUE : (pos == 2'd1) ? PH_GB   :
                       (pos == 2'd2) ? PH_GR   : PH_RED;
            2'd2: ph = (pos == 2'd0) ? PH_GR   : (pos == 2'd1) ? PH_RED  :
                       (pos == 2'd2) ? PH_BLUE : PH_GB;
            default: ph = (pos == 2'd0) ? PH_GB : (pos == 2'd1) ? PH_BLUE :
                          (pos == 2'd2) ? PH_RED : PH_GR;
        endcase
        return ph;
    endfunction

    // Lower clamp first, then upper, so the upper bound wins when they cross.
    function automatic logic [GAIN_W-1:0] clamp_gain(input logic [DIV_N_W-1:0] g,
                                                     input logic [GAIN_W-1:0] lo,
                                                     input logic [GAIN_W-1:0] hi);
        logic [DIV_N_W-1:0] t;
        t = (g < DIV_N_W'(lo)) ? DIV_N_W'(lo) : g;
        t = (t > DIV_N_W'(hi)) ? DIV_N_W'(hi) : t;
        return t[GAIN_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> design/gwb_front.sv
// Front end: accepts samples, tracks raster position and frame count, classifies the phase.
`timescale 1ns / 1ps
`default_nettype none
module gwb_front
    import gwb_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cfg_t                cfg,
    input  wire logic                accept,
    input  wire logic                opcode,
    input  wire logic [SAMPLE_W-1:0] sample,
    input  wire logic                last,
    output cmd_t                     cmd
);

    logic [POS_W-1:0]    col_reg, col_next;
    logic [POS_W-1:0]    row_reg, row_next;
    logic [SCOUNT_W-1:0] count_reg, count_next;
    logic [FW_W-1:0]     wlim;
    logic [2*FW_W-1:0]   frame_size;
    logic [SCOUNT_W-1:0] count_inc;
    logic [FW_W-1:0]     col_plus;

    always_comb
    begin
        if (cfg.frame_width == '0)
            wlim = FW_W'(1);
        else if (cfg.frame_width > FW_W'(MAX_WIDTH))
            wlim = FW_W'(MAX_WIDTH);
        else
            wlim = cfg.frame_width;

        frame_size = cfg.frame_width * cfg.frame_height;
        count_inc  = (count_reg == SCOUNT_MAX) ? count_reg : count_reg + 1'b1;
        col_plus   = {1'b0, col_reg} + 1'b1;

        cmd.opcode   = opcode;
        cmd.sample   = sample;
        cmd.last     = last;
        cmd.phase    = phase_map(cfg.bayer_order, {row_reg[0], col_reg[0]});
        cmd.mismatch = ((2*FW_W)'(count_inc) != frame_size);

        col_next   = col_reg;
        row_next   = row_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (last)
            begin
                col_next   = '0;
                row_next   = '0;
                count_next = '0;
            end
            else
            begin
                count_next = count_inc;
                if (col_plus >= wlim)
                begin
                    col_next = '0;
                    row_next = (({1'b0, row_reg} + 1'b1) >= (POS_W+1)'(MAX_HEIGHT)) ?
                               '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_plus[POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> design/gwb_fifo.sv
// Four-entry command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module gwb_fifo
    import gwb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_data,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output cmd_t      head
);

    cmd_t       mem [4];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;

    always_comb
    begin
        full      = (cnt_reg == 3'd4);
        not_empty = (cnt_reg != 3'd0);
        head      = mem[rd_reg];
        wr_next   = push ? wr_reg + 1'b1 : wr_reg;
        rd_next   = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next  = cnt_reg + {2'b00, push} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

>>> design/gwb_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module gwb_div
    import gwb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [DIV_N_W-1:0] dividend,
    input  wire logic [DIV_D_W-1:0] divisor,
    output logic                    done,
    output logic [DIV_N_W-1:0]      quotient
);

    logic [DIV_N_W-1:0]   q_reg, q_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_D_W-1:0]   d_reg, d_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_D_W:0]     shifted;

    always_comb
    begin
        shifted   = {rem_reg, q_reg[DIV_N_W-1]};
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            d_next    = divisor;
            step_next = DIV_CNT_W'(DIV_N_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, d_reg})
            begin
                rem_next = DIV_D_W'(shifted - {1'b0, d_reg});
                q_next   = {q_reg[DIV_N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIV_D_W-1:0];
                q_next   = {q_reg[DIV_N_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        done     = done_reg;
        quotient = q_reg;
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule
`default_nettype wire

>>> design/gwb_back.sv
// Back end: phase accumulation, frame-end gain sequencer, gain application and result register.
`timescale 1ns / 1ps
`default_nettype none
module gwb_back
    import gwb_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cfg_t          cfg,
    input  wire logic          cmd_valid,
    input  wire cmd_t          cmd,
    output logic               cmd_pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic               kind,
    output logic [PIXEL_W-1:0] pixel_out,
    output logic [GAIN_W-1:0]  red_gain,
    output logic [GAIN_W-1:0]  blue_gain,
    output logic [1:0]         status
);

    typedef enum logic [6:0] {
        ST_RUN        = 7'b0000001,
        ST_MEAN_ISSUE = 7'b0000010,
        ST_MEAN_WAIT  = 7'b0000100,
        ST_REF        = 7'b0001000,
        ST_GAIN_ISSUE = 7'b0010000,
        ST_GAIN_WAIT  = 7'b0100000,
        ST_FINISH     = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [SUM_W-1:0]    sum_reg [PHASE_TOTAL];
    logic [SUM_W-1:0]    sum_next [PHASE_TOTAL];
    logic [CNT_W-1:0]    cnt_reg [PHASE_TOTAL];
    logic [CNT_W-1:0]    cnt_next [PHASE_TOTAL];
    logic [MEAN_W-1:0]   mean_reg [PHASE_TOTAL];
    logic [MEAN_W-1:0]   mean_next [PHASE_TOTAL];
    logic [1:0]          idx_reg, idx_next;
    logic [MEAN_W-1:0]   ref_reg, ref_next;
    logic [GAIN_W-1:0]   rg_reg, rg_next;
    logic [GAIN_W-1:0]   bg_reg, bg_next;
    logic [GAIN_W-1:0]   new_rg_reg, new_rg_next;
    logic [GAIN_W-1:0]   new_bg_reg, new_bg_next;
    logic [1:0]          fstat_reg, fstat_next;

    logic                ov_reg, ov_next;
    logic                kind_reg, kind_next;
    logic [PIXEL_W-1:0]  pix_reg, pix_next;
    logic [GAIN_W-1:0]   org_reg, org_next;
    logic [GAIN_W-1:0]   obg_reg, obg_next;
    logic [1:0]          ost_reg, ost_next;

    logic                out_free;
    logic                div_start;
    logic [DIV_N_W-1:0]  div_n;
    logic [DIV_D_W-1:0]  div_d;
    logic                div_done;
    logic [DIV_N_W-1:0]  div_q;

    logic [SUM_W:0]      sum_add;
    logic [GAIN_W-1:0]   app_gain;
    logic [SAMPLE_W+GAIN_W:0] app_prod;
    logic [MEAN_W:0]     ref_sum;
    logic [MEAN_W-1:0]   ref_val;
    logic [1:0]          gain_ph;
    logic [MEAN_W-1:0]   mean_eff;

    gwb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        out_free = !ov_reg || !out_stall;

        state_next  = state_reg;
        idx_next    = idx_reg;
        ref_next    = ref_reg;
        rg_next     = rg_reg;
        bg_next     = bg_reg;
        new_rg_next = new_rg_reg;
        new_bg_next = new_bg_reg;
        fstat_next  = fstat_reg;
        for (int i = 0; i < PHASE_TOTAL; i++)
        begin
            sum_next[i]  = sum_reg[i];
            cnt_next[i]  = cnt_reg[i];
            mean_next[i] = mean_reg[i];
        end

        ov_next   = ov_reg && out_stall;
        kind_next = kind_reg;
        pix_next  = pix_reg;
        org_next  = org_reg;
        obg_next  = obg_reg;
        ost_next  = ost_reg;

        div_start = 1'b0;
        div_n     = '0;
        div_d     = '0;
        cmd_pop   = 1'b0;

        sum_add  = {1'b0, sum_reg[cmd.phase]} + (SUM_W+1)'(cmd.sample);
        app_gain = (cmd.phase == PH_RED) ? rg_reg :
                   (cmd.phase == PH_BLUE) ? bg_reg : UNITY_GAIN;
        // The product plus rounding never reaches 2^27, so the shifted value
        // always fits the 15-bit pixel range and no saturation is needed.
        app_prod = (SAMPLE_W+GAIN_W+1)'(cmd.sample) * (SAMPLE_W+GAIN_W+1)'(app_gain)
                   + (SAMPLE_W+GAIN_W+1)'(2048);

        ref_sum = {1'b0, mean_reg[PH_GR]} + {1'b0, mean_reg[PH_GB]};
        ref_val = ref_sum[MEAN_W:1];
        gain_ph = (idx_reg[0] == 1'b0) ? PH_RED : PH_BLUE;
        mean_eff = (mean_reg[gain_ph] < cfg.mean_floor) ? ref_reg : mean_reg[gain_ph];

        unique case (state_reg)
            ST_RUN:
            begin
                if (cmd_valid && (cmd.opcode == OP_MEASURE || out_free))
                begin
                    cmd_pop = 1'b1;
                    if (cmd.opcode == OP_MEASURE)
                    begin
                        sum_next[cmd.phase] = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                        if (cnt_reg[cmd.phase] != CNT_MAX)
                            cnt_next[cmd.phase] = cnt_reg[cmd.phase] + 1'b1;
                        if (cmd.last)
                        begin
                            new_rg_next = UNITY_GAIN;
                            new_bg_next = UNITY_GAIN;
                            idx_next    = '0;
                            if (cmd.mismatch)
                            begin
                                fstat_next = STATUS_MISMATCH;
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                fstat_next = STATUS_OK;
                                state_next = ST_MEAN_ISSUE;
                            end
                        end
                    end
                    else
                    begin
                        ov_next   = 1'b1;
                        kind_next = KIND_PIXEL;
                        pix_next  = app_prod[PIXEL_W+11:12];
                        org_next  = rg_reg;
                        obg_next  = bg_reg;
                        ost_next  = (cmd.last && cmd.mismatch) ? STATUS_MISMATCH : STATUS_OK;
                    end
                end
            end
            ST_MEAN_ISSUE:
            begin
                if (cnt_reg[idx_reg] == '0)
                begin
                    mean_next[idx_reg] = '0;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == PH_BLUE)
                        state_next = ST_REF;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_n      = {sum_reg[idx_reg], 8'd0};
                    div_d      = cnt_reg[idx_reg];
                    state_next = ST_MEAN_WAIT;
                end
            end
            ST_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    // Means stay below 1024 in Q.8, so the low bits hold the whole value.
                    mean_next[idx_reg] = div_q[MEAN_W-1:0];
                    idx_next = idx_reg + 1'b1;
                    state_next = (idx_reg == PH_BLUE) ? ST_REF : ST_MEAN_ISSUE;
                end
            end
            ST_REF:
            begin
                ref_next = ref_val;
                idx_next = '0;
                if (ref_val < cfg.mean_floor)
                begin
                    fstat_next = STATUS_DARK;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_GAIN_ISSUE;
                end
            end
            ST_GAIN_ISSUE:
            begin
                if (mean_eff == '0)
                begin
                    if (idx_reg[0] == 1'b0)
                        new_rg_next = clamp_gain(DIV_N_W'(cfg.gain_ceil), cfg.gain_floor,
                                                 cfg.gain_ceil);
                    else
                        new_bg_next = clamp_gain(DIV_N_W'(cfg.gain_ceil), cfg.gain_floor,
                                                 cfg.gain_ceil);
                    idx_next   = idx_reg + 1'b1;
                    state_next = (idx_reg[0] == 1'b1) ? ST_FINISH : ST_GAIN_ISSUE;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_n      = DIV_N_W'({ref_reg, 12'd0}) + DIV_N_W'(mean_eff >> 1);
                    div_d      = DIV_D_W'(mean_eff);
                    state_next = ST_GAIN_WAIT;
                end
            end
            ST_GAIN_WAIT:
            begin
                if (div_done)
                begin
                    if (idx_reg[0] == 1'b0)
                        new_rg_next = clamp_gain(div_q, cfg.gain_floor, cfg.gain_ceil);
                    else
                        new_bg_next = clamp_gain(div_q, cfg.gain_floor, cfg.gain_ceil);
                    idx_next   = idx_reg + 1'b1;
                    state_next = (idx_reg[0] == 1'b1) ? ST_FINISH : ST_GAIN_ISSUE;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    ov_next   = 1'b1;
                    kind_next = KIND_GAIN;
                    pix_next  = '0;
                    org_next  = new_rg_reg;
                    obg_next  = new_bg_reg;
                    ost_next  = fstat_reg;
                    rg_next   = new_rg_reg;
                    bg_next   = new_bg_reg;
                    for (int i = 0; i < PHASE_TOTAL; i++)
                    begin
                        sum_next[i] = '0;
                        cnt_next[i] = '0;
                    end
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        out_valid = ov_reg;
        kind      = kind_reg;
        pixel_out = pix_reg;
        red_gain  = org_reg;
        blue_gain = obg_reg;
        status    = ost_reg;
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        pix_reg    <= pix_next;
        org_reg    <= org_next;
        obg_reg    <= obg_next;
        ost_reg    <= ost_next;
        ref_reg    <= ref_next;
        new_rg_reg <= new_rg_next;
        new_bg_reg <= new_bg_next;
        fstat_reg  <= fstat_next;
        idx_reg    <= idx_next;
        for (int i = 0; i < PHASE_TOTAL; i++)
            mean_reg[i] <= mean_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            ov_reg    <= 1'b0;
            rg_reg    <= UNITY_GAIN;
            bg_reg    <= UNITY_GAIN;
            for (int i = 0; i < PHASE_TOTAL; i++)
            begin
                sum_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            rg_reg    <= rg_next;
            bg_reg    <= bg_next;
            for (int i = 0; i < PHASE_TOTAL; i++)
            begin
                sum_reg[i] <= sum_next[i];
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

endmodule
`default_nettype wire

>>> design/grey_world_white_balance.sv
// Top level of the grey-world automatic white balance block for raw Bayer samples.
//
//   Channel   Handshake              Payload
//   -------   --------------------   --------------------------------------------
//   input     in_valid/in_stall      opcode, sample, last
//   output    out_valid/out_stall    kind, pixel_out, red_gain, blue_gain, status
//   config    cfg_we                 cfg_index, cfg_data
//
// Measure and apply samples need no divider work in the back end, so the block
// sustains one transaction per clock while no stalled result holds back apply
// samples. A measure sample marked last starts the gain sequencer: up to four
// mean divisions and two gain divisions in the shared bit-serial divider,
// during which the four-entry queue fills and then stalls the input. Reset is
// asynchronous and active low; it restores the register defaults and unity gains.
// A stalled result holds in the output register while the back end may still
// absorb measure samples.
`timescale 1ns / 1ps
`default_nettype none
module grey_world_white_balance
    import gwb_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                opcode,
    input  wire logic [SAMPLE_W-1:0] sample,
    input  wire logic                last,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     kind,
    output logic [PIXEL_W-1:0]       pixel_out,
    output logic [GAIN_W-1:0]        red_gain,
    output logic [GAIN_W-1:0]        blue_gain,
    output logic [1:0]               status,
    input  wire logic                cfg_we,
    input  wire logic [IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic accept;
    logic q_full;
    logic q_valid;
    logic q_pop;
    cmd_t front_cmd;
    cmd_t q_head;

    // Configuration registers; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  cfg_next.frame_width  = cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: cfg_next.frame_height = cfg_data[FW_W-1:0];
                REG_BAYER_ORDER:  cfg_next.bayer_order  = cfg_data[1:0];
                REG_MIN_MEAN:     cfg_next.mean_floor   = cfg_data[MEAN_W-1:0];
                REG_MIN_GAIN:     cfg_next.gain_floor   = cfg_data[GAIN_W-1:0];
                REG_MAX_GAIN:     cfg_next.gain_ceil    = cfg_data[GAIN_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
        in_stall = q_full;
        accept   = in_valid && !q_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= FW_W'(4096);
            cfg_reg.frame_height <= FW_W'(4096);
            cfg_reg.bayer_order  <= 2'd0;
            cfg_reg.mean_floor   <= MEAN_W'(256);
            cfg_reg.gain_floor   <= GAIN_W'(2048);
            cfg_reg.gain_ceil    <= GAIN_W'(16384);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end classifies each transaction by phase and frame count.
    gwb_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .accept (accept),
        .opcode (opcode),
        .sample (sample),
        .last   (last),
        .cmd    (front_cmd)
    );

    gwb_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    // Back end accumulates, computes gains at frame end, and applies them.
    gwb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (q_valid),
        .cmd       (q_head),
        .cmd_pop   (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .pixel_out (pixel_out),
        .red_gain  (red_gain),
        .blue_gain (blue_gain),
        .status    (status)
    );

endmodule
`default_nettype wire
